FILE: rtl/mt_pkg.sv
// Package with MT19937 constants, sequencer states and word-level helper functions.
`default_nettype none

package mt_pkg;

    localparam int MT_STATE_WORDS = 624;
    localparam int MT_SHIFT_OFFSET = 397;

    localparam logic [31:0] SEED_MULT  = 32'd1812433253;
    localparam logic [31:0] TWIST_XOR  = 32'h9908_b0df;
    localparam logic [31:0] TEMPER_B   = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C   = 32'hefc6_0000;
    localparam logic [31:0] HIGH_BIT   = 32'h8000_0000;
    localparam logic [31:0] LOW_BITS   = 32'h7fff_ffff;
    localparam logic [31:0] RESET_SEED = 32'd5489;

    localparam logic [1:0] OP_SEED     = 2'd0;
    localparam logic [1:0] OP_DRAW     = 2'd1;
    localparam logic [1:0] OP_INTERVAL = 2'd2;

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_SEED_INIT = 8'b0000_0010,
        ST_SEED_MUL  = 8'b0000_0100,
        ST_SEED_ADD  = 8'b0000_1000,
        ST_DRAW_CHK  = 8'b0001_0000,
        ST_DRAW_TEMP = 8'b0010_0000,
        ST_REGEN     = 8'b0100_0000,
        ST_DONE      = 8'b1000_0000
    } mt_state_t;

    function automatic logic [31:0] mt_temper(input logic [31:0] w);
        logic [31:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic logic [31:0] mt_twist(input logic [31:0] cur, input logic [31:0] nxt,
                                             input logic [31:0] far);
        logic [31:0] y;
        logic [31:0] v;
        y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
        v = far ^ (y >> 1);
        if (y[0]) begin
            v = v ^ TWIST_XOR;
        end
        return v;
    endfunction

    // smallest all-ones mask that covers the bound
    function automatic logic [31:0] mt_cover_mask(input logic [31:0] limit);
        logic [31:0] m;
        m = limit;
        m = m | (m >> 1);
        m = m | (m >> 2);
        m = m | (m >> 4);
        m = m | (m >> 8);
        m = m | (m >> 16);
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mt_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
`default_nettype none

module mt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr_a,
    input  wire logic [ADDR_W-1:0] raddr_b,
    output logic      [WIDTH-1:0]  rdata_a,
    output logic      [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

FILE: rtl/mt19937_random_generator_unit.sv
// Top level: MT19937 generator with seed, raw draw and bounded interval draw.
//
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  input   | s_valid s_ready s_opcode s_operand     | in
//  result  | m_valid m_ready m_random_word          | out
//
// Seed: writes word 0, then runs the shared 32x32 multiplier step and its add step per
// further word; no result transaction.
// Raw draw: DRAW_CHK, DRAW_TEMP and DONE to the output register, with a regeneration pass
// first when the block is used up, one word per cycle through the dual-read state RAM.
// Interval draw: as a raw draw, with another DRAW_CHK and DRAW_TEMP per rejected attempt
// and any regenerations; a zero bound goes straight to DONE.
// After reset the unit seeds itself with 5489, s_ready low until that seed pass ends.
// The output register holds a result while m_ready is low; the next transaction is
// accepted meanwhile, and a following result waits until the register frees.
`default_nettype none

module mt19937_random_generator_unit
    import mt_pkg::*;
#(
    parameter int STATE_WORDS = MT_STATE_WORDS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_opcode,
    input  wire logic [31:0] s_operand,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [31:0] m_random_word
);

    localparam int ADDR_W = $clog2(STATE_WORDS);
    localparam int IDX_W = $clog2(STATE_WORDS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);
    localparam logic [IDX_W-1:0] FULL_IDX = IDX_W'(STATE_WORDS);
    localparam logic [IDX_W:0] FAR_OFS = (IDX_W + 1)'(MT_SHIFT_OFFSET);
    localparam logic [IDX_W:0] WRAP = (IDX_W + 1)'(STATE_WORDS);

    mt_state_t state_reg, state_next;
    logic [1:0]        op_reg, op_next;
    logic [31:0]       limit_reg, limit_next;
    logic [31:0]       mask_reg, mask_next;
    logic [31:0]       p_reg, p_next;
    logic [31:0]       prod_reg, prod_next;
    logic [31:0]       cur_reg, cur_next;
    logic [31:0]       res_reg, res_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              stg_valid_reg, stg_valid_next;
    logic [ADDR_W-1:0] stg_k_reg, stg_k_next;
    logic              m_valid_reg, m_valid_next;
    logic [31:0]       m_word_reg, m_word_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [31:0]       ram_wdata;
    logic [ADDR_W-1:0] ram_raddr_a;
    logic [ADDR_W-1:0] ram_raddr_b;
    logic [31:0]       ram_rdata_a;
    logic [31:0]       ram_rdata_b;

    logic              out_free;
    logic [31:0]       tempered;
    logic [31:0]       masked;
    logic [31:0]       seed_word;
    logic [IDX_W:0]    far_sum;
    logic [IDX_W:0]    far_idx;

    mt_ram #(
        .WIDTH(32),
        .DEPTH(STATE_WORDS)
    ) u_state_ram (
        .aclk   (aclk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .raddr_a(ram_raddr_a),
        .raddr_b(ram_raddr_b),
        .rdata_a(ram_rdata_a),
        .rdata_b(ram_rdata_b)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_random_word = m_word_reg;
    assign out_free = !m_valid_reg || m_ready;

    assign tempered = mt_temper(ram_rdata_a);
    assign masked = tempered & mask_reg;
    assign seed_word = prod_reg + 32'(cnt_reg);
    assign far_sum = {1'b0, cnt_reg} + FAR_OFS;
    assign far_idx = (far_sum >= WRAP) ? (far_sum - WRAP) : far_sum;

    always_comb begin
        state_next = state_reg;
        op_next = op_reg;
        limit_next = limit_reg;
        mask_next = mask_reg;
        p_next = p_reg;
        prod_next = prod_reg;
        cur_next = cur_reg;
        res_next = res_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        stg_valid_next = stg_valid_reg;
        stg_k_next = stg_k_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_word_next = m_word_reg;
        ram_we = 1'b0;
        ram_waddr = '0;
        ram_wdata = p_reg;
        ram_raddr_a = '0;
        ram_raddr_b = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next = s_opcode;
                    limit_next = s_operand;
                    mask_next = mt_cover_mask(s_operand);
                    case (s_opcode)
                        OP_SEED: begin
                            p_next = s_operand;
                            state_next = ST_SEED_INIT;
                        end
                        OP_DRAW: begin
                            state_next = ST_DRAW_CHK;
                        end
                        OP_INTERVAL: begin
                            if (s_operand == 32'd0) begin
                                res_next = 32'd0;
                                state_next = ST_DONE;
                            end else begin
                                state_next = ST_DRAW_CHK;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SEED_INIT: begin
                ram_we = 1'b1;
                ram_waddr = '0;
                ram_wdata = p_reg;
                cnt_next = IDX_W'(1);
                state_next = ST_SEED_MUL;
            end
            ST_SEED_MUL: begin
                prod_next = SEED_MULT * (p_reg ^ (p_reg >> 30));
                state_next = ST_SEED_ADD;
            end
            ST_SEED_ADD: begin
                ram_we = 1'b1;
                ram_waddr = cnt_reg[ADDR_W-1:0];
                ram_wdata = seed_word;
                p_next = seed_word;
                if (cnt_reg == LAST_IDX) begin
                    idx_next = FULL_IDX;
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + IDX_W'(1);
                    state_next = ST_SEED_MUL;
                end
            end
            ST_DRAW_CHK: begin
                if (idx_reg >= FULL_IDX) begin
                    // word 0 read here primes the regeneration pass
                    ram_raddr_a = '0;
                    cnt_next = '0;
                    stg_valid_next = 1'b0;
                    state_next = ST_REGEN;
                end else begin
                    ram_raddr_a = idx_reg[ADDR_W-1:0];
                    state_next = ST_DRAW_TEMP;
                end
            end
            ST_DRAW_TEMP: begin
                idx_next = idx_reg + IDX_W'(1);
                if (op_reg == OP_DRAW) begin
                    res_next = tempered;
                    state_next = ST_DONE;
                end else if (masked <= limit_reg) begin
                    res_next = masked;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_DRAW_CHK;
                end
            end
            ST_REGEN: begin
                // read data of port A is the next word, i.e. the current word one step on
                cur_next = ram_rdata_a;
                if (cnt_reg != FULL_IDX) begin
                    ram_raddr_a = (cnt_reg == LAST_IDX) ? '0
                                                        : ADDR_W'(cnt_reg + IDX_W'(1));
                    ram_raddr_b = far_idx[ADDR_W-1:0];
                    cnt_next = cnt_reg + IDX_W'(1);
                    stg_valid_next = 1'b1;
                    stg_k_next = cnt_reg[ADDR_W-1:0];
                end else begin
                    stg_valid_next = 1'b0;
                end
                if (stg_valid_reg) begin
                    ram_we = 1'b1;
                    ram_waddr = stg_k_reg;
                    ram_wdata = mt_twist(cur_reg, ram_rdata_a, ram_rdata_b);
                    if (stg_k_reg == LAST_IDX[ADDR_W-1:0]) begin
                        idx_next = '0;
                        stg_valid_next = 1'b0;
                        state_next = ST_DRAW_CHK;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_word_next = res_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SEED_INIT;
            p_reg <= RESET_SEED;
            cnt_reg <= '0;
            idx_reg <= FULL_IDX;
            stg_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            p_reg <= p_next;
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            stg_valid_reg <= stg_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg <= op_next;
        limit_reg <= limit_next;
        mask_reg <= mask_next;
        prod_reg <= prod_next;
        cur_reg <= cur_next;
        res_reg <= res_next;
        stg_k_reg <= stg_k_next;
        m_word_reg <= m_word_next;
    end

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= FULL_IDX)
        else $error("read index beyond state block");

    a_temper_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DRAW_TEMP |-> $past(idx_reg) < FULL_IDX)
        else $error("tempering a word past the block end");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE || state_reg == ST_DONE) |-> !ram_we)
        else $error("state RAM written outside a seed or regeneration pass");

    a_bounded_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && op_reg == OP_INTERVAL) |-> res_reg <= limit_reg)
        else $error("interval result above bound");

    a_regen_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REGEN && state_next == ST_DRAW_CHK) |=> idx_reg == '0)
        else $error("read index not cleared after regeneration");

endmodule

`default_nettype wire
